/* rtl/core/blob_statistics_accumulator_unit_assert.svh */
// Assertion macros shared by the blob statistics RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BLOB_STATISTICS_ACCUMULATOR_UNIT_ASSERT_SVH
`define BLOB_STATISTICS_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define BSA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bsa_pkg.sv */
// Shared constants, types and helper functions of the blob statistics accumulator.
// No dependencies; every other file of the block but the assertion header imports this package.
package bsa_pkg;

	// Field geometry.
	localparam int COORD_BITS = 6;
	localparam int TEMP_BITS  = 12;
	localparam int MAX_PIXELS = 4096;

	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
	localparam int SUMC_W = COORD_BITS + $clog2(MAX_PIXELS);
	localparam int SUMT_W = TEMP_BITS + $clog2(MAX_PIXELS);
	localparam int BOX_W  = COORD_BITS + 1;

	// Fixed-point fraction bits of the reported statistics.
	localparam int CFRAC  = 4;
	localparam int AFRAC  = 8;
	localparam int CENT_W = COORD_BITS + CFRAC;
	localparam int MEAN_W = TEMP_BITS + CFRAC;
	localparam int ASP_W  = BOX_W + AFRAC;

	// Serial divider sizing.
	localparam int DIV_W  = (CNT_W > BOX_W) ? CNT_W : BOX_W;
	localparam int QN_W   = (MEAN_W > ASP_W) ? ((MEAN_W > CENT_W) ? MEAN_W : CENT_W)
		: ((ASP_W > CENT_W) ? ASP_W : CENT_W);
	localparam int STEP_W = $clog2(QN_W + 1);
	localparam int DVD_W  = SUMT_W + CFRAC;

	// Running blob state.
	typedef struct packed {
		logic [CNT_W-1:0]         count;
		logic [COORD_BITS-1:0]    lo_x;
		logic [COORD_BITS-1:0]    lo_y;
		logic [COORD_BITS-1:0]    hi_x;
		logic [COORD_BITS-1:0]    hi_y;
		logic [SUMC_W-1:0]        sum_x;
		logic [SUMC_W-1:0]        sum_y;
		logic signed [SUMT_W-1:0] sum_t;
	} blob_stats_t;

	// Request to the serial divider.
	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  rem_init;
		logic [QN_W-1:0]   sh_init;
		logic [DIV_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	// Status and result of the serial divider.
	typedef struct packed {
		logic            busy;
		logic            done;
		logic [QN_W-1:0] quot;
	} div_rsp_t;

	// One result item.
	typedef struct packed {
		logic [CNT_W-1:0]         pixel_count;
		logic [COORD_BITS-1:0]    min_x;
		logic [COORD_BITS-1:0]    min_y;
		logic [COORD_BITS-1:0]    max_x;
		logic [COORD_BITS-1:0]    max_y;
		logic [BOX_W-1:0]         box_width;
		logic [BOX_W-1:0]         box_height;
		logic [CENT_W-1:0]        centroid_x;
		logic [CENT_W-1:0]        centroid_y;
		logic signed [MEAN_W-1:0] mean_temperature;
		logic [ASP_W-1:0]         aspect;
		logic                     ignored;
	} blob_result_t;

	// Splits a dividend for an n-step division: the bits above the quotient
	// length seed the remainder, the low n bits are shifted in one per step.
	function automatic div_req_t div_setup(logic [DVD_W-1:0] dvd, int unsigned n,
		logic [DIV_W-1:0] divisor);
		div_req_t r;
		r          = '0;
		r.rem_init = DIV_W'(dvd >> n);
		r.sh_init  = QN_W'(dvd << (QN_W - n));
		r.divisor  = divisor;
		r.steps    = STEP_W'(n);
		return r;
	endfunction

endpackage

/* rtl/core/bsa_in_if.sv */
// Input channel of the blob statistics accumulator: valid/ready plus pixel payload.
// Depends on bsa_pkg for the field widths.
interface bsa_in_if import bsa_pkg::*; ();

	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [COORD_BITS-1:0]       pixel_x;
	logic [COORD_BITS-1:0]       pixel_y;
	logic signed [TEMP_BITS-1:0] temperature;

	modport source (output valid, mode, pixel_x, pixel_y, temperature, input ready);
	modport sink (input valid, mode, pixel_x, pixel_y, temperature, output ready);

endinterface

/* rtl/core/bsa_out_if.sv */
// Output channel of the blob statistics accumulator: valid/ready plus result payload.
// Depends on bsa_pkg for the field widths.
interface bsa_out_if import bsa_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [CNT_W-1:0]         pixel_count;
	logic [COORD_BITS-1:0]    min_x;
	logic [COORD_BITS-1:0]    min_y;
	logic [COORD_BITS-1:0]    max_x;
	logic [COORD_BITS-1:0]    max_y;
	logic [BOX_W-1:0]         box_width;
	logic [BOX_W-1:0]         box_height;
	logic [CENT_W-1:0]        centroid_x;
	logic [CENT_W-1:0]        centroid_y;
	logic signed [MEAN_W-1:0] mean_temperature;
	logic [ASP_W-1:0]         aspect;
	logic                     ignored;

	modport source (output valid, pixel_count, min_x, min_y, max_x, max_y, box_width,
		box_height, centroid_x, centroid_y, mean_temperature, aspect, ignored,
		input ready);
	modport sink (input valid, pixel_count, min_x, min_y, max_x, max_y, box_width,
		box_height, centroid_x, centroid_y, mean_temperature, aspect, ignored,
		output ready);

endinterface

/* rtl/core/bsa_accum.sv */
// Blob state registers: pixel count, bounding box and running sums.
// Depends on bsa_pkg for widths and the blob_stats_t type.
module bsa_accum import bsa_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        mode,
	input  logic [COORD_BITS-1:0]       pixel_x,
	input  logic [COORD_BITS-1:0]       pixel_y,
	input  logic signed [TEMP_BITS-1:0] temperature,
	output blob_stats_t                 stats,
	output logic                        ignored
);

	blob_stats_t stats_q;
	blob_stats_t grow;
	logic        ign_q;
	logic        full;
	logic        first;

	assign full  = (stats_q.count == CNT_W'(MAX_PIXELS));
	assign first = (stats_q.count == '0);

	// State after absorbing one pixel. The first pixel sets the box to itself.
	always_comb begin
		grow       = stats_q;
		grow.count = stats_q.count + CNT_W'(1);
		grow.sum_x = stats_q.sum_x + SUMC_W'(pixel_x);
		grow.sum_y = stats_q.sum_y + SUMC_W'(pixel_y);
		grow.sum_t = stats_q.sum_t + SUMT_W'(temperature);
		if (first || pixel_x < stats_q.lo_x) begin
			grow.lo_x = pixel_x;
		end
		if (first || pixel_x > stats_q.hi_x) begin
			grow.hi_x = pixel_x;
		end
		if (first || pixel_y < stats_q.lo_y) begin
			grow.lo_y = pixel_y;
		end
		if (first || pixel_y > stats_q.hi_y) begin
			grow.hi_y = pixel_y;
		end
	end

	// A clear empties the blob; a pixel on a full blob only raises the flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q <= '0;
			ign_q   <= 1'b0;
		end else if (take) begin
			if (mode) begin
				stats_q <= '0;
				ign_q   <= 1'b0;
			end else if (full) begin
				ign_q <= 1'b1;
			end else begin
				stats_q <= grow;
				ign_q   <= 1'b0;
			end
		end
	end

	assign stats   = stats_q;
	assign ignored = ign_q;

endmodule

/* rtl/core/bsa_serdiv.sv */
// Bit-serial restoring divider: one quotient bit per cycle, shared by all quotients.
// Depends on bsa_pkg for div_req_t and div_rsp_t, and on the assertion macro header.
`include "blob_statistics_accumulator_unit_assert.svh"

module bsa_serdiv import bsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  rem_q;
	logic [QN_W-1:0]   sh_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W+1:0]  trial;
	logic              qbit;
	logic [DIV_W-1:0]  rem_next;

	// Trial subtraction of the divisor from the remainder with the next bit shifted in.
	assign trial    = {1'b0, rem_q, sh_q[QN_W-1]} - {2'b00, divisor_q};
	assign qbit     = ~trial[DIV_W+1];
	assign rem_next = qbit ? trial[DIV_W-1:0] : {rem_q[DIV_W-2:0], sh_q[QN_W-1]};

	// Step counter and handshake with the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and shift register; quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			sh_q      <= req.sh_init;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[QN_W-2:0], qbit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

	`BSA_ASSERT_IMPL(a_rem_below_divisor, busy_q, rem_q < divisor_q, "remainder reached divisor")
	`BSA_ASSERT_IMPL(a_start_when_idle, req.start, !busy_q, "divider started while busy")
	`BSA_ASSERT_NEXT(a_last_step_done, busy_q && cnt_q == STEP_W'(1), done_q && !busy_q, "no done after last step")

endmodule

/* rtl/core/blob_statistics_accumulator_unit.sv */
// A non-empty blob runs all four divisions before its result is pushed; an empty blob skips them.
// A new item is taken only while the sequencer is idle, after the last result entered the output register.
// The four quotients run one after another through a bit-serial divider, one bit a cycle.
// The output register lets the next input transfer while a result waits.
// arst_n clears the blob to empty, idles the sequencer and drops result valid.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if, bsa_accum, bsa_serdiv and the assertion header.
`include "blob_statistics_accumulator_unit_assert.svh"

module blob_statistics_accumulator_unit import bsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bsa_in_if.sink     pixels,
	bsa_out_if.source  stats
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	localparam logic [1:0] OP_CX  = 2'd0;
	localparam logic [1:0] OP_CY  = 2'd1;
	localparam logic [1:0] OP_MT  = 2'd2;
	localparam logic [1:0] OP_ASP = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        op_q;
	logic              accept;
	logic              out_load;
	logic              ovalid_q;
	blob_stats_t       st;
	logic              ign;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	logic [CENT_W-1:0] cx_q;
	logic [CENT_W-1:0] cy_q;
	logic [MEAN_W-1:0] mt_q;
	logic [ASP_W-1:0]  asp_q;
	logic [BOX_W-1:0]  box_w;
	logic [BOX_W-1:0]  box_h;
	logic              nonempty;
	logic              t_neg;
	logic [SUMT_W-1:0] t_mag;
	blob_result_t      res_d;
	blob_result_t      res_q;

	assign accept       = pixels.valid && pixels.ready;
	assign pixels.ready = (state_q == ST_IDLE);
	assign out_load     = (state_q == ST_PUSH) && (!ovalid_q || stats.ready);

	bsa_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (accept),
		.mode        (pixels.mode),
		.pixel_x     (pixels.pixel_x),
		.pixel_y     (pixels.pixel_y),
		.temperature (pixels.temperature),
		.stats       (st),
		.ignored     (ign)
	);

	bsa_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Box size and temperature magnitude feeding the divisions.
	assign nonempty = (st.count != '0);
	assign box_w    = BOX_W'(st.hi_x) - BOX_W'(st.lo_x) + BOX_W'(1);
	assign box_h    = BOX_W'(st.hi_y) - BOX_W'(st.lo_y) + BOX_W'(1);
	assign t_neg    = st.sum_t[SUMT_W-1];
	assign t_mag    = t_neg ? SUMT_W'(-st.sum_t) : SUMT_W'(st.sum_t);

	// Operands of the current division.
	always_comb begin
		unique case (op_q)
			OP_CX:  div_req = div_setup(DVD_W'({st.sum_x, {CFRAC{1'b0}}}), CENT_W,
				DIV_W'(st.count));
			OP_CY:  div_req = div_setup(DVD_W'({st.sum_y, {CFRAC{1'b0}}}), CENT_W,
				DIV_W'(st.count));
			OP_MT:  div_req = div_setup(DVD_W'({t_mag, {CFRAC{1'b0}}}), MEAN_W,
				DIV_W'(st.count));
			OP_ASP: div_req = div_setup(DVD_W'({box_w, {AFRAC{1'b0}}}), ASP_W,
				DIV_W'(box_h));
		endcase
		div_req.start = (state_q == ST_LOAD) && nonempty;
	end

	// Sequencer: one division per pass through LOAD and DIV, then push the result; an empty blob goes from LOAD to PUSH.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_CX;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOAD;
						op_q    <= OP_CX;
					end
				end
				ST_LOAD: begin
					state_q <= nonempty ? ST_DIV : ST_PUSH;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						if (op_q == OP_ASP) begin
							state_q <= ST_PUSH;
						end else begin
							op_q    <= op_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Quotient registers; an empty blob reports zero for every quotient.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && !nonempty) begin
			cx_q  <= '0;
			cy_q  <= '0;
			mt_q  <= '0;
			asp_q <= '0;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			case (op_q)
				OP_CX:   cx_q  <= div_rsp.quot[CENT_W-1:0];
				OP_CY:   cy_q  <= div_rsp.quot[CENT_W-1:0];
				OP_MT:   mt_q  <= div_rsp.quot[MEAN_W-1:0];
				default: asp_q <= div_rsp.quot[ASP_W-1:0];
			endcase
		end
	end

	// Assemble the result; the mean takes the sign of the temperature sum.
	always_comb begin
		res_d.pixel_count      = st.count;
		res_d.min_x            = st.lo_x;
		res_d.min_y            = st.lo_y;
		res_d.max_x            = st.hi_x;
		res_d.max_y            = st.hi_y;
		res_d.box_width        = nonempty ? box_w : '0;
		res_d.box_height       = nonempty ? box_h : '0;
		res_d.centroid_x       = cx_q;
		res_d.centroid_y       = cy_q;
		res_d.mean_temperature = t_neg ? MEAN_W'(-mt_q) : MEAN_W'(mt_q);
		res_d.aspect           = asp_q;
		res_d.ignored          = ign;
	end

	// Output register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (stats.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign stats.valid            = ovalid_q;
	assign stats.pixel_count      = res_q.pixel_count;
	assign stats.min_x            = res_q.min_x;
	assign stats.min_y            = res_q.min_y;
	assign stats.max_x            = res_q.max_x;
	assign stats.max_y            = res_q.max_y;
	assign stats.box_width        = res_q.box_width;
	assign stats.box_height       = res_q.box_height;
	assign stats.centroid_x       = res_q.centroid_x;
	assign stats.centroid_y       = res_q.centroid_y;
	assign stats.mean_temperature = res_q.mean_temperature;
	assign stats.aspect           = res_q.aspect;
	assign stats.ignored          = res_q.ignored;

	`BSA_ASSERT_IMPL(a_done_in_div, div_rsp.done, state_q == ST_DIV, "divider result outside division phase")
	`BSA_ASSERT_IMPL(a_empty_zero, state_q == ST_PUSH && !nonempty, cx_q == '0 && cy_q == '0 && mt_q == '0 && asp_q == '0, "empty blob with nonzero quotient")
	`BSA_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_LOAD && op_q == OP_CX, "transfer did not start the sequence")

endmodule

/* verif/tb_blob_statistics_accumulator_unit.sv */
// Self-checking testbench of blob_statistics_accumulator_unit: random valid/ready pauses on both
// channels, a running blob model that predicts every result, and a field-by-field compare.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if and the RTL of the block.
module tb_blob_statistics_accumulator_unit;
	import bsa_pkg::*;

	localparam int CYCLE_LIMIT   = 4000000;
	localparam int SETTLE_CYCLES = 200;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam int TEMP_MIN      = -(1 << (TEMP_BITS - 1));
	localparam int TEMP_MAX      = (1 << (TEMP_BITS - 1)) - 1;

	typedef enum logic {
		MODE_ADD   = 1'b0,
		MODE_CLEAR = 1'b1
	} pixel_mode_t;

	typedef struct {
		pixel_mode_t                 mode;
		logic [COORD_BITS-1:0]       x;
		logic [COORD_BITS-1:0]       y;
		logic signed [TEMP_BITS-1:0] temp;
		bit                          wait_drain;
	} pixel_item_t;

	logic clk = 1'b0;
	logic arst_n;

	bsa_in_if  pixels_if ();
	bsa_out_if stats_if ();

	blob_statistics_accumulator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels_if),
		.stats  (stats_if)
	);

	pixel_item_t  pixel_queue[$];
	blob_result_t stats_expected[$];
	blob_stats_t  blob_model;
	pixel_item_t  cur_pixel;
	logic         stats_taken;
	int unsigned  sent_count = 0;
	int unsigned  done_count = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  send_gap = 0;
	int unsigned  send_quiet = 0;
	int unsigned  stall_left = 0;
	int unsigned  stall_quiet = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one item to the blob model (adds a pixel or clears it) and returns the statistics it reports.
	function automatic blob_result_t absorb_pixel(pixel_item_t item);
		blob_result_t r;
		logic         dropped;
		longint       cnt, tsum, sx, sy;
		int unsigned  w, h;
		r       = '0;
		dropped = 1'b0;
		if (item.mode == MODE_CLEAR) begin
			blob_model = '0;
		end else if (blob_model.count >= MAX_PIXELS) begin
			dropped = 1'b1;
		end else begin
			if (blob_model.count == '0) begin
				blob_model.lo_x = item.x;
				blob_model.hi_x = item.x;
				blob_model.lo_y = item.y;
				blob_model.hi_y = item.y;
			end else begin
				if (item.x > blob_model.hi_x) blob_model.hi_x = item.x;
				if (item.x < blob_model.lo_x) blob_model.lo_x = item.x;
				if (item.y > blob_model.hi_y) blob_model.hi_y = item.y;
				if (item.y < blob_model.lo_y) blob_model.lo_y = item.y;
			end
			blob_model.count = blob_model.count + 1'b1;
			blob_model.sum_x = blob_model.sum_x + item.x;
			blob_model.sum_y = blob_model.sum_y + item.y;
			blob_model.sum_t = blob_model.sum_t + item.temp;
		end

		// An empty blob reports zero statistics.
		if (blob_model.count != '0) begin
			w    = blob_model.hi_x - blob_model.lo_x + 1;
			h    = blob_model.hi_y - blob_model.lo_y + 1;
			cnt  = blob_model.count;
			tsum = blob_model.sum_t;
			sx   = blob_model.sum_x;
			sy   = blob_model.sum_y;
			r.pixel_count      = blob_model.count;
			r.min_x            = blob_model.lo_x;
			r.min_y            = blob_model.lo_y;
			r.max_x            = blob_model.hi_x;
			r.max_y            = blob_model.hi_y;
			r.box_width        = BOX_W'(w);
			r.box_height       = BOX_W'(h);
			r.centroid_x       = CENT_W'((sx * 16) / cnt);
			r.centroid_y       = CENT_W'((sy * 16) / cnt);
			r.mean_temperature = MEAN_W'((tsum * 16) / cnt);
			r.aspect           = ASP_W'((w * 256) / h);
		end
		r.ignored = dropped;
		return r;
	endfunction

	// Pause length in cycles: mostly none or short, a few long, with quiet stretches.
	function automatic int unsigned pause_length(inout int unsigned quiet);
		int unsigned pick;
		if (quiet != 0) begin
			quiet--;
			return 0;
		end
		pick = $urandom_range(0, 199);
		if (pick == 0) begin
			quiet = $urandom_range(40, 200);
			return 0;
		end
		if (pick < 100) return 0;
		if (pick < 170) return $urandom_range(1, 3);
		if (pick < 192) return $urandom_range(4, 15);
		return $urandom_range(20, 80);
	endfunction

	task automatic report_mismatch(string msg);
		$display("result %0d: %s", done_count, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, $signed(got),
				$signed(want)));
	endtask

	// Checks the result of one output transfer against the oldest prediction.
	task automatic check_stats();
		blob_result_t want;
		if (stats_expected.size() == 0) begin
			report_mismatch("result arrived with no prediction pending");
			return;
		end
		want = stats_expected.pop_front();
		compare_field("pixel_count", stats_if.pixel_count, want.pixel_count);
		compare_field("min_x", stats_if.min_x, want.min_x);
		compare_field("min_y", stats_if.min_y, want.min_y);
		compare_field("max_x", stats_if.max_x, want.max_x);
		compare_field("max_y", stats_if.max_y, want.max_y);
		compare_field("box_width", stats_if.box_width, want.box_width);
		compare_field("box_height", stats_if.box_height, want.box_height);
		compare_field("centroid_x", stats_if.centroid_x, want.centroid_x);
		compare_field("centroid_y", stats_if.centroid_y, want.centroid_y);
		compare_field("mean_temperature", stats_if.mean_temperature,
			want.mean_temperature);
		compare_field("aspect", stats_if.aspect, want.aspect);
		compare_field("ignored", stats_if.ignored, want.ignored);
	endtask

	task automatic queue_item(pixel_mode_t mode, int x, int y, int t, bit drain = 1'b0);
		pixel_item_t item;
		item.mode       = mode;
		item.x          = COORD_BITS'(x);
		item.y          = COORD_BITS'(y);
		item.temp       = TEMP_BITS'(t);
		item.wait_drain = drain;
		pixel_queue.push_back(item);
	endtask

	function automatic int rand_coord();
		return $urandom_range(0, COORD_MAX);
	endfunction

	// Full-range temperature with the two extremes favored.
	function automatic int rand_temp();
		int pick;
		int t;
		pick = $urandom_range(0, 7);
		if (pick == 0) return TEMP_MIN;
		if (pick == 1) return TEMP_MAX;
		t = $urandom_range(0, TEMP_MAX - TEMP_MIN);
		return t + TEMP_MIN;
	endfunction

	function automatic int coord_near(int center, int spread);
		int off;
		int v;
		off = $urandom_range(0, 2 * spread);
		v   = center + off - spread;
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return v;
	endfunction

	// Driver: presents pending pixels and updates the model on each input transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_if.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (pixels_if.valid && pixels_if.ready) begin
				stats_expected.push_back(absorb_pixel(cur_pixel));
				sent_count++;
			end
			if (!pixels_if.valid || pixels_if.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					pixels_if.valid <= 1'b0;
				end else if (pixel_queue.size() != 0 &&
					!(pixel_queue[0].wait_drain && done_count != sent_count)) begin
					cur_pixel = pixel_queue.pop_front();
					pixels_if.valid       <= 1'b1;
					pixels_if.mode        <= cur_pixel.mode;
					pixels_if.pixel_x     <= cur_pixel.x;
					pixels_if.pixel_y     <= cur_pixel.y;
					pixels_if.temperature <= cur_pixel.temp;
					send_gap = pause_length(send_quiet);
				end else begin
					pixels_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transfer and stalls ready at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			stats_taken = stats_if.valid && stats_if.ready;
			if (stats_taken) begin
				check_stats();
				done_count <= done_count + 1;
			end
			if (stall_left == 0 && (stats_taken || $urandom_range(0, 31) == 0))
				stall_left = pause_length(stall_quiet);
			if (stall_left != 0) begin
				stall_left--;
				stats_if.ready <= 1'b0;
			end else begin
				stats_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          random_end;
		int          n, cx, cy, spread;
		pixel_mode_t mode;

		pixels_if.valid       = 1'b0;
		pixels_if.mode        = MODE_ADD;
		pixels_if.pixel_x     = '0;
		pixels_if.pixel_y     = '0;
		pixels_if.temperature = '0;
		stats_if.ready        = 1'b0;
		blob_model            = '0;
		arst_n                = 1'b0;

		// Directed part: empty blob, first pixel, box and temperature extremes.
		queue_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_temp());
		queue_item(MODE_ADD, 0, 0, TEMP_MIN);
		queue_item(MODE_ADD, COORD_MAX, COORD_MAX, TEMP_MAX);
		queue_item(MODE_CLEAR, COORD_MAX, COORD_MAX, -1);
		queue_item(MODE_ADD, 10, 40, TEMP_MAX);
		// A smaller row has to lower the minimum row.
		queue_item(MODE_ADD, 20, 30, 0);
		queue_item(MODE_ADD, 5, 50, -1);
		queue_item(MODE_ADD, 15, 35, -7);
		// Widest possible box over a single row.
		queue_item(MODE_CLEAR, 0, 0, 0);
		queue_item(MODE_ADD, 0, 5, 100);
		queue_item(MODE_ADD, COORD_MAX, 5, -100);
		// Tallest possible box over a single column.
		queue_item(MODE_CLEAR, 21, 42, TEMP_MIN);
		queue_item(MODE_ADD, 7, 0, TEMP_MIN);
		queue_item(MODE_ADD, 7, COORD_MAX, TEMP_MIN);
		// Negative means that truncate toward zero.
		queue_item(MODE_CLEAR, 0, 0, 0);
		queue_item(MODE_ADD, 33, 21, TEMP_MIN);
		queue_item(MODE_ADD, 42, 42, 1);
		queue_item(MODE_ADD, 42, 42, 0);
		queue_item(MODE_ADD, 1, 62, -3);
		queue_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_temp());

		// Random part: mostly a clear and a run of pixels around a center, some noise.
		random_end = pixel_queue.size() + RANDOM_ITEMS;
		while (pixel_queue.size() < random_end) begin
			if ($urandom_range(0, 19) < 3) begin
				n = $urandom_range(1, 6);
				repeat (n) begin
					mode = pixel_mode_t'($urandom_range(0, 1));
					queue_item(mode, rand_coord(), rand_coord(), rand_temp());
				end
			end else begin
				cx     = rand_coord();
				cy     = rand_coord();
				spread = ($urandom_range(0, 3) == 0) ? COORD_MAX : $urandom_range(0, 12);
				n      = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
					: $urandom_range(1, 25);
				queue_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_temp(),
					$urandom_range(0, 39) == 0);
				repeat (n)
					queue_item(MODE_ADD, coord_near(cx, spread), coord_near(cy, spread),
						rand_temp());
			end
		end

		// Fill the blob to its limit after a full drain, then pixels that must be dropped.
		queue_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_temp(), 1'b1);
		repeat (MAX_PIXELS)
			queue_item(MODE_ADD, rand_coord(), rand_coord(), TEMP_MIN);
		repeat (6)
			queue_item(MODE_ADD, rand_coord(), rand_coord(), rand_temp());
		queue_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_temp());
		queue_item(MODE_ADD, rand_coord(), rand_coord(), rand_temp());

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Wait for the last input transfer and every predicted result.
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || pixels_if.valid || done_count != sent_count);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (stats_expected.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived",
				stats_expected.size()));
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
